// ----- design/arsq_pkg.sv -----
// Shared types and constants for the arrival-sorted release queue.
// Used by the controller, the datapath, the top level and the testbench.
package arsq_pkg;

   localparam int DEPTH_DEF   = 16;
   localparam int MAX_RESULTS = 16;
   localparam int ID_W        = 8;
   localparam int TIME_W      = 16;
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_TICK   = 2'd1,
      OP_REWIND = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] tstamp;
   } slot_type;

   typedef struct packed {
      logic latch;
      logic rewind;
      logic clear;
      logic ins_start;
      logic rd_ins;
      logic rd_head;
      logic wr_shift;
      logic wr_new;
      logic p_dec;
      logic tick_start;
      logic take;
      logic out_rej;
      logic out_last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic p_zero;
      logic head_lt_fill;
      logic n_lt_max;
      logic hold_v;
      logic gt;
      logic eq;
      logic out_free;
   } stat_type;

endpackage

// ----- design/arsq_ctrl.sv -----
// Sequencer for insert search, tick release, rewind and clear.
// Depends on arsq_pkg; drives the datapath through cmd_type, reads stat_type.
module arsq_ctrl import arsq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  logic     [1:0] req_op,
   input  stat_type stat,
   output logic     req_tready,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CHK,
      ST_INS_CMP,
      ST_REJ,
      ST_TK_CHK,
      ST_TK_CMP,
      ST_TK_LAST
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      accept;

   assign accept     = req_tvalid && ready_ff;
   assign req_tready = ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               case (op_type'(req_op))
                  OP_INSERT: begin
                     if (stat.full) begin
                        state_in = ST_REJ;
                     end else begin
                        cmd.ins_start = 1'b1;
                        state_in      = ST_INS_CHK;
                     end
                  end
                  OP_TICK: begin
                     cmd.tick_start = 1'b1;
                     state_in       = ST_TK_CHK;
                  end
                  OP_REWIND: cmd.rewind = 1'b1;
                  OP_CLEAR:  cmd.clear  = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_INS_CHK: begin
            if (stat.p_zero) begin
               cmd.wr_new = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.rd_ins = 1'b1;
               state_in   = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (stat.gt) begin
               cmd.wr_shift = 1'b1;
               cmd.p_dec    = 1'b1;
               state_in     = ST_INS_CHK;
            end else begin
               cmd.wr_new = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_REJ: begin
            if (stat.out_free) begin
               cmd.out_rej = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_TK_CHK: begin
            if (stat.head_lt_fill && stat.n_lt_max) begin
               cmd.rd_head = 1'b1;
               state_in    = ST_TK_CMP;
            end else if (stat.hold_v) begin
               state_in = ST_TK_LAST;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TK_CMP: begin
            if (stat.eq) begin
               if (!stat.hold_v || stat.out_free) begin
                  cmd.take = 1'b1;
                  state_in = ST_TK_CHK;
               end
            end else if (stat.hold_v) begin
               state_in = ST_TK_LAST;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TK_LAST: begin
            if (stat.out_free) begin
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign ready_in = (state_in == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule

// ----- design/arsq_datapath.sv -----
// Slot memory, fill and head counters, hold and result registers.
// Depends on arsq_pkg; steered by arsq_ctrl through cmd_type.
module arsq_datapath import arsq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ID_W-1:0]   in_id,
   input  logic [TIME_W-1:0] in_arrival,
   input  logic [TIME_W-1:0] in_now,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [ID_W-1:0]   rsp_id,
   output logic [TIME_W-1:0] rsp_arrival,
   output logic              rsp_status,
   output logic              rsp_last
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   slot_type          mem [DEPTH];
   slot_type          rd_ff;
   slot_type          hold_ff;
   logic              hold_v_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] arr_ff;
   logic [TIME_W-1:0] now_ff;
   logic [CNT_W-1:0]  p_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  head_ff;
   logic [RES_W-1:0]  n_ff;
   logic [CNT_W-1:0]  p_m1;
   logic [IDX_W-1:0]  rd_addr;
   logic              rd_en;
   logic              wr_en;
   slot_type          wr_data;
   logic              out_free;
   logic              load_out;
   logic              valid_ff;
   slot_type          out_ff;
   logic              status_ff;
   logic              last_ff;

   assign p_m1     = p_ff - CNT_W'(1);
   assign rd_en    = cmd.rd_ins || cmd.rd_head;
   assign rd_addr  = cmd.rd_head ? head_ff[IDX_W-1:0] : p_m1[IDX_W-1:0];
   assign wr_en    = cmd.wr_shift || cmd.wr_new;
   assign wr_data  = cmd.wr_shift ? rd_ff : slot_type'{id: id_ff, tstamp: arr_ff};
   assign out_free = !valid_ff || rsp_tready;
   assign load_out = cmd.out_rej || cmd.out_last || (cmd.take && hold_v_ff);

   assign stat.full         = (fill_ff == CNT_W'(DEPTH));
   assign stat.p_zero       = (p_ff == '0);
   assign stat.head_lt_fill = (head_ff < fill_ff);
   assign stat.n_lt_max     = (n_ff < RES_W'(MAX_RESULTS));
   assign stat.hold_v       = hold_v_ff;
   assign stat.gt           = (rd_ff.tstamp > arr_ff);
   assign stat.eq           = (rd_ff.tstamp == now_ff);
   assign stat.out_free     = out_free;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[p_ff[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         id_ff  <= in_id;
         arr_ff <= in_arrival;
         now_ff <= in_now;
      end
      if (cmd.ins_start) begin
         p_ff <= fill_ff;
      end else if (cmd.p_dec) begin
         p_ff <= p_m1;
      end
      if (cmd.take) begin
         hold_ff <= rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         head_ff   <= '0;
         n_ff      <= '0;
         hold_v_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            fill_ff <= '0;
         end else if (cmd.wr_new) begin
            fill_ff <= fill_ff + CNT_W'(1);
         end
         if (cmd.clear || cmd.rewind) begin
            head_ff <= '0;
         end else if ((cmd.wr_new && (p_ff <= head_ff)) || cmd.take) begin
            head_ff <= head_ff + CNT_W'(1);
         end
         if (cmd.tick_start) begin
            n_ff <= '0;
         end else if (cmd.take) begin
            n_ff <= n_ff + RES_W'(1);
         end
         if (cmd.tick_start || cmd.out_last) begin
            hold_v_ff <= 1'b0;
         end else if (cmd.take) begin
            hold_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_out) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_rej) begin
         out_ff    <= slot_type'{id: id_ff, tstamp: arr_ff};
         status_ff <= 1'b1;
         last_ff   <= 1'b1;
      end else if (load_out) begin
         out_ff    <= hold_ff;
         status_ff <= 1'b0;
         last_ff   <= cmd.out_last;
      end
   end

   assign rsp_tvalid  = valid_ff;
   assign rsp_id      = out_ff.id;
   assign rsp_arrival = out_ff.tstamp;
   assign rsp_status  = status_ff;
   assign rsp_last    = last_ff;

endmodule

// ----- design/arrival_sorted_release_queue.sv -----
// Insert: walks from the tail, reading each stored slot into a registered read buffer and moving
// it aside while its time is later; tick: reads and releases head jobs whose time equals now.
// One transaction is in work at a time; a finished result waits in the output register.
// Synchronous reset empties the list, rewinds the head and drops any pending result;
// slot contents are not cleared. Built from arsq_ctrl and arsq_datapath (arsq_pkg).
module arrival_sorted_release_queue import arsq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // job_id[7:0], arrival[23:8], now[39:24]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_id[7:0], out_arrival[23:8]
   output logic        rsp_tuser,   // status[0]
   output logic        rsp_tlast
);

   cmd_type           cmd;
   stat_type          stat;
   logic [ID_W-1:0]   rsp_id;
   logic [TIME_W-1:0] rsp_arrival;

   arsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   arsq_datapath #(.DEPTH(DEPTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .in_id       (req_tdata[7:0]),
      .in_arrival  (req_tdata[23:8]),
      .in_now      (req_tdata[39:24]),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_id      (rsp_id),
      .rsp_arrival (rsp_arrival),
      .rsp_status  (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {rsp_arrival, rsp_id};

endmodule

// ----- design/arsq_checker.sv -----
// Port-level checks for arrival_sorted_release_queue, attached by bind.
// Does not import arsq_pkg; its port widths are written out as literals.
module arsq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("reject result without last");

   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (!rsp_tvalid || rsp_tready) |=> !rsp_tvalid)
      else $error("result appeared in the cycle after a transaction was taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind arrival_sorted_release_queue arsq_checker u_arsq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ----- sim/tb_arrival_sorted_release_queue.sv -----
// Self-checking bench for arrival_sorted_release_queue: directed and random
// insert/tick/rewind/clear traffic with stalls on both streams, checked
// against a behavioral queue predictor. Depends on arsq_pkg and the design.
module tb_arrival_sorted_release_queue;
   import arsq_pkg::*;

   localparam int QDEPTH     = DEPTH_DEF;
   localparam int N_ITEMS    = 410;
   localparam int LONG_HOLD  = 300;
   localparam int SETTLE     = 80;
   localparam int MAX_REPORT = 10;
   localparam int MAX_GAP    = 13;

   typedef enum logic [1:0] {
      CMD_ITEM  = 2'd0,
      CMD_DRAIN = 2'd1,
      CMD_HOLD  = 2'd2
   } cmd_kind;

   typedef struct {
      cmd_kind           kind;
      op_type            op;
      logic [ID_W-1:0]   job;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] now;
   } job_cmd;

   typedef struct {
      logic              status;
      logic [ID_W-1:0]   job;
      logic [TIME_W-1:0] stamp;
      logic              tail;
   } release_rec;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // job_id[7:0], arrival[23:8], now[39:24]
   logic [1:0]  req_tuser  = '0;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // out_id[7:0], out_arrival[23:8]
   logic        rsp_tuser;         // status[0]
   logic        rsp_tlast;

   arrival_sorted_release_queue #(.DEPTH(QDEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   logic [TIME_W-1:0] list_time [QDEPTH];
   logic [ID_W-1:0]   list_job  [QDEPTH];
   int unsigned       list_fill = 0;
   int unsigned       list_head = 0;

   job_cmd      cmd_q[$];
   release_rec  pending_releases[$];

   bit          req_fire   = 1'b0;
   bit          rsp_fire   = 1'b0;
   bit          hold_start = 1'b0;
   bit          long_hold  = 1'b0;
   int unsigned tx_gap     = 0;
   int unsigned rx_gap     = 0;
   int unsigned n_items    = 0;
   int unsigned n_accepted = 0;
   int unsigned n_results  = 0;
   int unsigned n_errors   = 0;
   int unsigned n_released = 0;
   int unsigned n_rejected = 0;
   int unsigned op_count [4] = '{default: 0};

   always #2 clock = ~clock;

   function automatic int unsigned draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic void flag_error(string what);
      n_errors++;
      if (n_errors <= MAX_REPORT) $display("ERROR at %0t: %s", $time, what);
   endfunction

   function automatic void add_op(op_type op, logic [ID_W-1:0] job,
                                  logic [TIME_W-1:0] arrival, logic [TIME_W-1:0] now);
      job_cmd c;
      c.kind = CMD_ITEM;
      c.op = op;
      c.job = job;
      c.arrival = arrival;
      c.now = now;
      cmd_q.push_back(c);
      n_items++;
   endfunction

   function automatic void add_mark(cmd_kind kind);
      job_cmd c;
      c.kind = kind;
      c.op = OP_REWIND;
      c.job = '0;
      c.arrival = '0;
      c.now = '0;
      cmd_q.push_back(c);
   endfunction

   function automatic void predict_releases(op_type op, logic [ID_W-1:0] job,
                                            logic [TIME_W-1:0] arrival,
                                            logic [TIME_W-1:0] now);
      int unsigned pos;
      int          n;
      release_rec  r;
      case (op)
         OP_INSERT: begin
            if (list_fill >= QDEPTH) begin
               r.status = 1'b1;
               r.job = job;
               r.stamp = arrival;
               r.tail = 1'b1;
               pending_releases.push_back(r);
            end else begin
               pos = 0;
               while (pos < list_fill && list_time[pos] <= arrival) pos++;
               for (int i = list_fill; i > pos; i--) begin
                  list_time[i] = list_time[i-1];
                  list_job[i]  = list_job[i-1];
               end
               list_time[pos] = arrival;
               list_job[pos]  = job;
               list_fill++;
               if (pos <= list_head && list_head < QDEPTH) list_head++;
            end
         end
         OP_TICK: begin
            n = 0;
            while (n < MAX_RESULTS && list_head < list_fill &&
                   list_time[list_head] == now) begin
               r.status = 1'b0;
               r.job = list_job[list_head];
               r.stamp = list_time[list_head];
               r.tail = 1'b0;
               pending_releases.push_back(r);
               list_head++;
               n++;
            end
            if (n > 0) pending_releases[pending_releases.size()-1].tail = 1'b1;
         end
         OP_REWIND: begin
            list_head = 0;
         end
         default: begin
            list_fill = 0;
            list_head = 0;
         end
      endcase
   endfunction

   // monitor: predict on input transactions, check output transactions
   always @(posedge clock) begin : monitor_proc
      release_rec want;
      release_rec got;
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      if (req_fire) begin
         n_accepted++;
         op_count[req_tuser]++;
         predict_releases(op_type'(req_tuser), req_tdata[7:0], req_tdata[23:8],
                          req_tdata[39:24]);
      end
      if (rsp_fire) begin
         n_results++;
         got.status = rsp_tuser;
         got.job    = rsp_tdata[7:0];
         got.stamp  = rsp_tdata[23:8];
         got.tail   = rsp_tlast;
         if (got.status === 1'b1) n_rejected++;
         else n_released++;
         if (pending_releases.size() == 0) begin
            flag_error($sformatf("unexpected result status=%b id=%0d arrival=%0d last=%b",
                                 got.status, got.job, got.stamp, got.tail));
         end else begin
            want = pending_releases.pop_front();
            if (got.status !== want.status || got.job !== want.job ||
                got.stamp !== want.stamp || got.tail !== want.tail)
               flag_error($sformatf({"result %0d: expected status=%b id=%0d arrival=%0d ",
                                     "last=%b, got status=%b id=%0d arrival=%0d last=%b"},
                                    n_results, want.status, want.job, want.stamp,
                                    want.tail, got.status, got.job, got.stamp, got.tail));
         end
      end
   end

   // driver: present the next pending transaction, hold it until accepted
   always @(negedge clock) begin : drive_proc
      logic   valid_n;
      job_cmd c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         valid_n = 1'b0;
         if (req_fire) tx_gap = draw_gap(((n_accepted / 32) % 3) == 1);
         if (tx_gap > 0) begin
            tx_gap--;
         end else if (cmd_q.size() != 0) begin
            if (cmd_q[0].kind == CMD_HOLD) begin
               hold_start = 1'b1;
               void'(cmd_q.pop_front());
            end else if (cmd_q[0].kind == CMD_DRAIN) begin
               if (pending_releases.size() == 0) void'(cmd_q.pop_front());
            end else begin
               c = cmd_q.pop_front();
               req_tuser <= c.op;
               req_tdata <= {c.now, c.arrival, c.job};
               valid_n = 1'b1;
            end
         end
         req_tvalid <= valid_n;
      end
   end

   // receiver: random stall before each result
   always @(negedge clock) begin : receive_proc
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fire) rx_gap = draw_gap(((n_results / 40) % 3) == 2);
         if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !long_hold;
         end
      end
   end

   // long receiver hold-off, counted in clock cycles
   initial begin
      wait (hold_start);
      @(posedge clock);
      long_hold = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      long_hold = 1'b0;
   end

   initial begin
      #(4 * 600_000);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus_proc
      logic [TIME_W-1:0] base;
      logic [TIME_W-1:0] burst_time;
      int unsigned       span;
      int unsigned       fill;

      // directed: empty tick, extremes, ties, exhausted-list insert, clear
      add_op(OP_TICK,   8'h00, 16'h0000, 16'h0000);
      add_op(OP_INSERT, 8'h00, 16'h0000, 16'hFFFF);
      add_op(OP_INSERT, 8'hFF, 16'hFFFF, 16'h0000);
      add_op(OP_INSERT, 8'hA5, 16'h5A5A, 16'hA5A5);
      add_op(OP_INSERT, 8'h5A, 16'h0000, 16'h5A5A);
      add_op(OP_REWIND, 8'hFF, 16'hFFFF, 16'hFFFF);
      add_op(OP_TICK,   8'hFF, 16'hFFFF, 16'h0000);
      add_op(OP_TICK,   8'h00, 16'h0000, 16'h0000);
      add_op(OP_TICK,   8'h00, 16'h0000, 16'h5A5A);
      add_op(OP_TICK,   8'h00, 16'h0000, 16'hFFFF);
      add_op(OP_TICK,   8'h00, 16'h0000, 16'hFFFF);
      add_op(OP_INSERT, 8'h07, 16'd100,  16'h0000);
      add_op(OP_TICK,   8'h00, 16'h0000, 16'd100);
      add_op(OP_REWIND, 8'h00, 16'h0000, 16'h0000);
      add_op(OP_TICK,   8'h00, 16'h0000, 16'h0000);
      add_op(OP_CLEAR,  8'hFF, 16'hFFFF, 16'hFFFF);
      add_op(OP_TICK,   8'h00, 16'h0000, 16'h0000);
      add_op(OP_CLEAR,  8'h00, 16'h0000, 16'h0000);

      // fill the list, reject one, then stall the output during a full burst
      burst_time = 16'($urandom);
      repeat (QDEPTH) add_op(OP_INSERT, 8'($urandom), burst_time, 16'($urandom));
      add_op(OP_INSERT, 8'($urandom), 16'($urandom), 16'($urandom));
      add_op(OP_REWIND, 8'($urandom), 16'($urandom), 16'($urandom));
      add_mark(CMD_HOLD);
      add_op(OP_TICK, 8'($urandom), 16'($urandom), burst_time);
      add_op(OP_INSERT, 8'($urandom), burst_time, 16'($urandom));
      add_op(OP_TICK, 8'($urandom), 16'($urandom), burst_time);
      add_op(OP_REWIND, 8'($urandom), 16'($urandom), 16'($urandom));
      add_op(OP_TICK, 8'($urandom), 16'($urandom), burst_time);
      add_mark(CMD_DRAIN);

      // random: load a narrow time window, rewind, walk the clock through it
      while (n_items < N_ITEMS) begin
         if ($urandom_range(0, 9) < 7) add_op(OP_CLEAR, 8'($urandom), 16'($urandom),
                                              16'($urandom));
         base = 16'($urandom);
         span = $urandom_range(0, 3);
         fill = $urandom_range(1, 18);
         repeat (fill) add_op(OP_INSERT, 8'($urandom), 16'(base + $urandom_range(0, span)),
                              16'($urandom));
         if ($urandom_range(0, 7) != 0) add_op(OP_REWIND, 8'($urandom), 16'($urandom),
                                                16'($urandom));
         for (int t = 0; t <= span + 1; t++) begin
            add_op(OP_TICK, 8'($urandom), 16'($urandom), 16'(base + t));
            if ($urandom_range(0, 5) == 0)
               add_op(OP_INSERT, 8'($urandom), 16'(base + $urandom_range(0, span)),
                      16'($urandom));
            if ($urandom_range(0, 7) == 0)
               add_op(OP_TICK, 8'($urandom), 16'($urandom), 16'(base + t));
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
               add_op(op_type'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                      16'($urandom));
         if ($urandom_range(0, 5) == 0) add_mark(CMD_DRAIN);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_q.size() != 0 || req_tvalid) @(posedge clock);
      while (pending_releases.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Run: %0d transactions (%0d insert, %0d tick, %0d rewind, %0d clear)",
               n_accepted, op_count[OP_INSERT], op_count[OP_TICK], op_count[OP_REWIND],
               op_count[OP_CLEAR]);
      $display("Results: %0d released jobs, %0d full rejections, %0d errors",
               n_released, n_rejected, n_errors);
      if (n_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/arsq_pkg.sv
design/arsq_ctrl.sv
design/arsq_datapath.sv
design/arrival_sorted_release_queue.sv
design/arsq_checker.sv
sim/tb_arrival_sorted_release_queue.sv
